// ===== rtl/mitf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the max intensity window filter
// no dependencies
package mitf_pkg;

  localparam int COL_W      = 11;
  localparam int ROW_W      = 13;
  localparam int RAD_W      = 3;
  localparam int SLOT_W     = 4;
  localparam int LVL_W      = 16;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS_Q8     = 2'd3;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // effective geometry after clamping
  typedef struct packed {
    logic [COL_W-1:0]  w;
    logic [ROW_W-1:0]  h;
    logic [RAD_W-1:0]  r;
    logic [SLOT_W-1:0] rows;
    logic [LVL_W-1:0]  levels;
  } geom_t;

  // one output pixel to compute
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic              last_px;
    logic              run_last;
  } job_t;

  // window of output (ocol,orow) fully received
  function automatic logic output_ready(input logic [ROW_W-1:0] irow,
                                        input logic [COL_W-1:0] icol,
                                        input logic [ROW_W-1:0] orow,
                                        input logic [COL_W-1:0] ocol,
                                        input geom_t g);
    logic [COL_W:0] nx;
    logic [ROW_W:0] ny;
    logic ok;
    nx = {1'b0, ocol} + (COL_W+1)'(g.r);
    if (nx > {1'b0, g.w} - 1'b1) nx = {1'b0, g.w} - 1'b1;
    ny = {1'b0, orow} + (ROW_W+1)'(g.r);
    if (ny > {1'b0, g.h} - 1'b1) ny = {1'b0, g.h} - 1'b1;
    ok = (orow < g.h) && (ocol < g.w);
    return ok && (({1'b0, irow} > ny) || (({1'b0, irow} == ny) && ({1'b0, icol} > nx)));
  endfunction

  // floor((r+g+b)/3) by reciprocal, exact for sums below 2048
  function automatic logic [CH_W-1:0] div3(input logic [PIX_W-1:0] p);
    logic [9:0]  s;
    logic [20:0] m;
    s = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
    m = 21'(s) * 21'd683;
    return m[18:11];
  endfunction

  // gain and saturate
  function automatic logic [CH_W-1:0] gain(input logic [CH_W-1:0] q,
                                           input logic [LVL_W-1:0] lv);
    logic [23:0] t;
    t = 24'(q) * 24'(lv);
    return (t[23:16] != 8'd0) ? 8'hFF : t[15:8];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] rows);
    return (s + 1'b1 == rows) ? '0 : s + 1'b1;
  endfunction

endpackage

// ===== rtl/mitf_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module mitf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mitf_queue.sv =====
`timescale 1ns / 1ps
// two entry job queue between front and back
// depends on mitf_pkg
module mitf_queue import mitf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = entry[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_job;
  end

endmodule

// ===== rtl/mitf_front.sv =====
`timescale 1ns / 1ps
// front end: accepts beats, writes the line store, tracks counters, issues output jobs
// depends on mitf_pkg
module mitf_front import mitf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int ADDR_W     = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  geom_t             g,
  input  logic              resync_req,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [PIX_W-1:0]  pix,
  input  logic              back_busy,
  input  logic              q_empty,
  input  logic              q_full,
  output logic              job_push,
  output job_t              job,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [PIX_W-1:0]  mem_wdata
);

  localparam int CNT_W = $clog2(MAX_RADIUS + 1);
  localparam int MOD_W = $clog2(ROW_W);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_EMIT = 3'b100
  } fstate_t;

  fstate_t           state;
  logic              pend;
  logic [COL_W-1:0]  in_col, out_col;
  logic [ROW_W-1:0]  in_row, out_row;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [MOD_W-1:0]  mod_bit;
  logic [SLOT_W-1:0] rem_in, rem_out;
  logic [CNT_W-1:0]  em_cnt, em_lim;

  // normalized counters at the start of a beat
  logic [COL_W-1:0]  n_in_col, n_out_col;
  logic [ROW_W-1:0]  n_in_row, n_out_row;
  logic [SLOT_W-1:0] n_in_slot, n_out_slot;

  always_comb begin
    n_in_col   = in_col;
    n_in_row   = in_row;
    n_in_slot  = in_slot;
    n_out_col  = out_col;
    n_out_row  = out_row;
    n_out_slot = out_slot;
    if (in_col >= g.w) begin
      n_in_col  = '0;
      n_in_row  = in_row + 1'b1;
      n_in_slot = slot_inc(in_slot, g.rows);
    end
    if (n_in_row >= g.h) begin
      n_in_row = g.h;
      n_in_col = '0;
    end
    if (out_col >= g.w) begin
      n_out_col  = '0;
      n_out_row  = out_row + 1'b1;
      n_out_slot = slot_inc(out_slot, g.rows);
    end
    if (n_out_row >= g.h) begin
      n_in_col   = '0;
      n_in_row   = '0;
      n_in_slot  = '0;
      n_out_col  = '0;
      n_out_row  = '0;
      n_out_slot = '0;
    end
  end

  // input position after storing a pixel
  logic [COL_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_row;
  logic [SLOT_W-1:0] a_slot;

  always_comb begin
    a_col  = n_in_col + 1'b1;
    a_row  = n_in_row;
    a_slot = n_in_slot;
    if (a_col >= g.w) begin
      a_col  = '0;
      a_row  = n_in_row + 1'b1;
      a_slot = slot_inc(n_in_slot, g.rows);
    end
  end

  // emit decision and lookahead to the following output
  logic              cur_rdy, nxt_rdy, last_px, run_last;
  logic [COL_W-1:0]  e_col;
  logic [ROW_W-1:0]  e_row;
  logic [SLOT_W-1:0] e_slot;

  always_comb begin
    cur_rdy = output_ready(in_row, in_col, out_row, out_col, g);
    last_px = (out_col == g.w - 1'b1) && (out_row == g.h - 1'b1);
    e_col   = out_col + 1'b1;
    e_row   = out_row;
    e_slot  = out_slot;
    if (e_col >= g.w) begin
      e_col  = '0;
      e_row  = out_row + 1'b1;
      e_slot = slot_inc(out_slot, g.rows);
    end
    nxt_rdy  = !last_px && output_ready(in_row, in_col, e_row, e_col, g);
    run_last = (em_cnt == em_lim) || !nxt_rdy;
  end

  // handshake and outputs
  logic accept;

  assign in_ready  = (state == F_IDLE) && !pend && !back_busy && q_empty;
  assign accept    = in_valid && in_ready;
  assign mem_we    = accept && (cmd == CMD_PIXEL) && (n_in_row < g.h);
  assign mem_waddr = ADDR_W'(n_in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(n_in_col);
  assign mem_wdata = pix;
  assign job_push  = (state == F_EMIT) && cur_rdy && !q_full;
  assign job       = '{col: out_col, row: out_row, slot: out_slot,
                       last_px: last_px, run_last: run_last};

  // remainder step for the store slot resync
  logic [SLOT_W:0] t_in, t_out;

  always_comb begin
    t_in  = {rem_in, in_row[mod_bit]};
    t_out = {rem_out, out_row[mod_bit]};
    if (t_in >= {1'b0, g.rows}) t_in = t_in - {1'b0, g.rows};
    if (t_out >= {1'b0, g.rows}) t_out = t_out - {1'b0, g.rows};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      pend     <= 1'b0;
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      mod_bit  <= '0;
      rem_in   <= '0;
      rem_out  <= '0;
      em_cnt   <= '0;
      em_lim   <= '0;
    end else begin
      if (resync_req) pend <= 1'b1;
      unique case (state)
        F_IDLE: begin
          if (pend && in_valid && !back_busy && q_empty) begin
            // geometry changed: wrap counters, then recompute slots
            in_col   <= n_in_col;
            in_row   <= n_in_row;
            out_col  <= n_out_col;
            out_row  <= n_out_row;
            mod_bit  <= MOD_W'(ROW_W - 1);
            rem_in   <= '0;
            rem_out  <= '0;
            state    <= F_MOD;
          end else if (accept) begin
            in_col   <= n_in_col;
            in_row   <= n_in_row;
            in_slot  <= n_in_slot;
            out_col  <= n_out_col;
            out_row  <= n_out_row;
            out_slot <= n_out_slot;
            em_cnt   <= '0;
            if (cmd == CMD_DRAIN) begin
              em_lim <= '0;
              state  <= F_EMIT;
            end else if (n_in_row < g.h) begin
              in_col  <= a_col;
              in_row  <= a_row;
              in_slot <= a_slot;
              em_lim  <= CNT_W'(MAX_RADIUS);
              state   <= F_EMIT;
            end
          end
        end
        F_MOD: begin
          rem_in  <= t_in[SLOT_W-1:0];
          rem_out <= t_out[SLOT_W-1:0];
          mod_bit <= mod_bit - 1'b1;
          if (mod_bit == '0) begin
            in_slot  <= t_in[SLOT_W-1:0];
            out_slot <= t_out[SLOT_W-1:0];
            pend     <= resync_req;
            state    <= F_IDLE;
          end
        end
        F_EMIT: begin
          if (!cur_rdy) begin
            state <= F_IDLE;
          end else if (!q_full) begin
            em_cnt <= em_cnt + 1'b1;
            if (last_px) begin
              in_col   <= '0;
              in_row   <= '0;
              in_slot  <= '0;
              out_col  <= '0;
              out_row  <= '0;
              out_slot <= '0;
            end else begin
              out_col  <= e_col;
              out_row  <= e_row;
              out_slot <= e_slot;
            end
            if (run_last) state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mitf_back.sv =====
`timescale 1ns / 1ps
// back end: scans the window of one job and holds the chosen pixel for output
// depends on mitf_pkg
module mitf_back import mitf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int ADDR_W    = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  geom_t             g,
  input  logic              job_valid,
  input  job_t              job_in,
  output logic              job_pop,
  output logic              busy,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [PIX_W-1:0]  mem_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   red_out,
  output logic [CH_W-1:0]   green_out,
  output logic [CH_W-1:0]   blue_out,
  output logic [CH_W-1:0]   alpha_out,
  output logic              run_last,
  output logic              frame_end
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  bstate_t           state;
  job_t              jb;
  logic [SLOT_W-1:0] wi, wj;
  logic              issuing, v1, v2, first;
  logic [CH_W-1:0]   q2;
  logic [PIX_W-1:0]  p2;
  logic [PIX_W-1:0]  best;
  logic [CH_W-1:0]   best_i;
  logic [SLOT_W-1:0] span;

  assign span    = {g.r, 1'b0};
  assign busy    = (state == B_SCAN);
  assign job_pop = (state == B_IDLE) && job_valid;

  // clamped window coordinate to store address
  logic signed [ROW_W+1:0] yy, dy;
  logic signed [COL_W+1:0] xx;
  logic [ROW_W-1:0]        ry;
  logic [COL_W-1:0]        rx;
  logic signed [5:0]       sl;

  always_comb begin
    yy = $signed((ROW_W+2)'(jb.row)) + $signed((ROW_W+2)'(wj))
         - $signed((ROW_W+2)'(g.r));
    if (yy < 0) ry = '0;
    else if (yy > $signed((ROW_W+2)'(g.h - 1'b1))) ry = g.h - 1'b1;
    else ry = yy[ROW_W-1:0];
    xx = $signed((COL_W+2)'(jb.col)) + $signed((COL_W+2)'(wi))
         - $signed((COL_W+2)'(g.r));
    if (xx < 0) rx = '0;
    else if (xx > $signed((COL_W+2)'(g.w - 1'b1))) rx = g.w - 1'b1;
    else rx = xx[COL_W-1:0];
    dy = $signed((ROW_W+2)'(ry)) - $signed((ROW_W+2)'(jb.row));
    sl = $signed(6'(jb.slot)) + dy[5:0];
    if (sl < 0) sl = sl + $signed(6'(g.rows));
    else if (sl >= $signed(6'(g.rows))) sl = sl - $signed(6'(g.rows));
    mem_raddr = ADDR_W'(sl[SLOT_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx);
  end

  // intensity of the pixel in the compare stage
  logic [CH_W-1:0] it2;
  assign it2 = gain(q2, g.levels);

  // scan sequencer and running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      first     <= 1'b0;
      out_valid <= 1'b0;
      wi        <= '0;
      wj        <= '0;
    end else begin
      v1 <= (state == B_SCAN) && issuing;
      v2 <= v1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            jb      <= job_in;
            wi      <= '0;
            wj      <= '0;
            issuing <= 1'b1;
            first   <= 1'b1;
            state   <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (issuing) begin
            if (wi == span) begin
              wi <= '0;
              if (wj == span) issuing <= 1'b0;
              else wj <= wj + 1'b1;
            end else begin
              wi <= wi + 1'b1;
            end
          end
          if (v2) begin
            first <= 1'b0;
            if (first || it2 > best_i) begin
              best   <= p2;
              best_i <= it2;
            end
          end
          if (!issuing && !v1 && !v2) state <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // pipeline payload and output register
  always_ff @(posedge clk) begin
    if (v1) begin
      q2 <= div3(mem_rdata);
      p2 <= mem_rdata;
    end
    if (state == B_DONE && (!out_valid || out_ready)) begin
      red_out   <= best[7:0];
      green_out <= best[15:8];
      blue_out  <= best[23:16];
      alpha_out <= best[31:24];
      run_last  <= jb.run_last;
      frame_end <= jb.last_px;
    end
  end

endmodule

// ===== rtl/max_intensity_window_filter_core.sv =====
`timescale 1ns / 1ps
// top level of the max intensity window filter: config registers, front, queue, back, store
// depends on mitf_pkg, mitf_ram, mitf_queue, mitf_front, mitf_back
//
// Usage: RGBA pixels enter in raster order on the in channel (valid/ready) with
// cmd = 0; after the last pixel of a frame, beats with cmd = 1 fetch the
// outputs still pending, one per beat. Results leave on the out channel
// (valid/ready); run_last marks the last result of an input beat and frame_end
// the final pixel of the frame.
// Each output pixel scans its (2r+1)^2 window through the single read port of
// the line store, one entry a cycle; a beat can give up to MAX_RADIUS+1
// results, and a pixel beat may also complete no window.
// The next beat is accepted once the window scans of the previous beat are
// done, while its last result may still wait in the output register.
// Reset clears all counters and loads the default geometry; the line store
// is not cleared. After a register write the first beat waits while
// the row slots of the store are recomputed.
// A stalled receiver holds the result in the output register and, through
// the job queue, stops the front after two more jobs.
module max_intensity_window_filter_core import mitf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [CH_W-1:0]       red_in,
  input  logic [CH_W-1:0]       green_in,
  input  logic [CH_W-1:0]       blue_in,
  input  logic [CH_W-1:0]       alpha_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       red_out,
  output logic [CH_W-1:0]       green_out,
  output logic [CH_W-1:0]       blue_out,
  output logic [CH_W-1:0]       alpha_out,
  output logic                  run_last,
  output logic                  frame_end
);

  localparam int DEPTH  = MAX_WIDTH * (2 * MAX_RADIUS + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [COL_W-1:0] image_width;
  logic [ROW_W-1:0] image_height;
  logic [RAD_W-1:0] window_radius;
  logic [LVL_W-1:0] levels_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= COL_W'(640);
      image_height  <= ROW_W'(480);
      window_radius <= RAD_W'(1);
      levels_q8     <= LVL_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[COL_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[ROW_W-1:0];
        REG_WINDOW_RADIUS: window_radius <= cfg_data[RAD_W-1:0];
        REG_LEVELS_Q8:     levels_q8     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry
  geom_t g;

  always_comb begin
    g.w = image_width;
    if (image_width == '0) g.w = COL_W'(1);
    else if ({1'b0, image_width} > (COL_W+1)'(MAX_WIDTH)) g.w = COL_W'(MAX_WIDTH);
    g.h = image_height;
    if (image_height == '0) g.h = ROW_W'(1);
    else if ({1'b0, image_height} > (ROW_W+1)'(MAX_HEIGHT)) g.h = ROW_W'(MAX_HEIGHT);
    g.r = window_radius;
    if (window_radius == '0) g.r = RAD_W'(1);
    else if ({1'b0, window_radius} > (RAD_W+1)'(MAX_RADIUS)) g.r = RAD_W'(MAX_RADIUS);
    g.rows   = {g.r, 1'b1};
    g.levels = levels_q8;
  end

  // interconnect
  logic              back_busy, q_empty, q_full, job_push, job_pop, mem_we;
  job_t              push_job, pop_job;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [PIX_W-1:0]  mem_wdata, mem_rdata;

  mitf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .g          (g),
    .resync_req (cfg_write),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pix        ({alpha_in, blue_in, green_in, red_in}),
    .back_busy  (back_busy),
    .q_empty    (q_empty),
    .q_full     (q_full),
    .job_push   (job_push),
    .job        (push_job),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  mitf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  mitf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mitf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .g         (g),
    .job_valid (!q_empty),
    .job_in    (pop_job),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule
